>>> hdl/prbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbc_pkg
// Shared types and constants of the prefix rectangle balance counter.
// ----------------------------------------------------------------------------
package prbc_pkg;

  localparam int CNT_W  = 21;
  localparam int PAIR_W = 2 * CNT_W;
  localparam int CFG_W  = 11;

  localparam logic [CFG_W-1:0] CFG_COLUMNS_RST = 11'd1024;
  localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};

  localparam logic [1:0] SYM_X = 2'd1;
  localparam logic [1:0] SYM_Y = 2'd2;

  typedef struct packed {
    logic       grid_start;
    logic [1:0] cell_req;
  } in_item_t;

  typedef struct packed {
    logic             match;
    logic [CNT_W-1:0] total;
  } out_item_t;

endpackage

>>> hdl/prbc_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbc_row_mem
// Column prefix store of the prior row: one write and one registered read
// port, read data held while no read is issued.
// ----------------------------------------------------------------------------
module prbc_row_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [prbc_pkg::PAIR_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [prbc_pkg::PAIR_W-1:0] rd_data
);

  logic [prbc_pkg::PAIR_W-1:0] mem [DEPTH];
  logic [prbc_pkg::PAIR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/prbc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbc_core
// Raster scan front end, read-modify-write stage with write forwarding and
// output register.
// ----------------------------------------------------------------------------
module prbc_core #(
  parameter int CW       = 10,
  parameter int RW       = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [RW-1:0]               cols_act,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  prbc_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output prbc_pkg::out_item_t         out_data,
  output logic                        mem_wr_en,
  output logic [CW-1:0]               mem_wr_addr,
  output logic [prbc_pkg::PAIR_W-1:0] mem_wr_data,
  output logic                        mem_rd_en,
  output logic [CW-1:0]               mem_rd_addr,
  input  logic [prbc_pkg::PAIR_W-1:0] mem_rd_data
);

  localparam int CNT_W = prbc_pkg::CNT_W;

  // front state
  logic [RW-1:0] rsx_r, rsy_r;
  logic [CW-1:0] col_r;
  logic          first_r;

  // read-modify-write stage
  logic                        s1_valid_r;
  logic                        s1_start_r;
  logic                        s1_first_r;
  logic [RW-1:0]               s1_rsx_r, s1_rsy_r;
  logic [CW-1:0]               s1_col_r;
  logic                        fwd_r;
  logic [prbc_pkg::PAIR_W-1:0] fwd_data_r;
  logic [CNT_W-1:0]            total_r;

  logic                out_valid_r;
  prbc_pkg::out_item_t out_data_r;

  logic          acc, out_free, s1_adv, row_end;
  logic [RW-1:0] rsx0, rsy0, rsx1, rsy1;
  logic [CW-1:0] col0;
  logic          first0;

  logic [prbc_pkg::PAIR_W-1:0] prior;
  logic [CNT_W-1:0]            px, py, cx, cy, base, total_nxt;
  logic [CNT_W:0]              sum_x, sum_y;
  logic                        hit;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_adv;
  assign acc      = in_valid && in_ready;

  always_comb begin
    rsx0   = in_data.grid_start ? '0 : rsx_r;
    rsy0   = in_data.grid_start ? '0 : rsy_r;
    col0   = in_data.grid_start ? '0 : col_r;
    first0 = in_data.grid_start | first_r;
    rsx1   = (in_data.cell_req == prbc_pkg::SYM_X) ? RW'(rsx0 + RW'(1)) : rsx0;
    rsy1   = (in_data.cell_req == prbc_pkg::SYM_Y) ? RW'(rsy0 + RW'(1)) : rsy0;
    row_end = (32'(col0) + 32'd1) >= 32'(cols_act);
  end

  always_comb begin
    prior = s1_first_r ? '0 : (fwd_r ? fwd_data_r : mem_rd_data);
    px    = prior[prbc_pkg::PAIR_W-1:CNT_W];
    py    = prior[CNT_W-1:0];
    sum_x = {1'b0, px} + (CNT_W+1)'(s1_rsx_r);
    sum_y = {1'b0, py} + (CNT_W+1)'(s1_rsy_r);
    cx    = sum_x[CNT_W] ? prbc_pkg::CNT_MAX : sum_x[CNT_W-1:0];
    cy    = sum_y[CNT_W] ? prbc_pkg::CNT_MAX : sum_y[CNT_W-1:0];
    hit   = (cx != '0) && (cx == cy);
    base  = s1_start_r ? '0 : total_r;
    if (hit && (base != prbc_pkg::CNT_MAX)) begin
      total_nxt = base + CNT_W'(1);
    end else begin
      total_nxt = base;
    end
  end

  assign mem_wr_en   = s1_adv;
  assign mem_wr_addr = s1_col_r;
  assign mem_wr_data = {cx, cy};
  assign mem_rd_en   = acc;
  assign mem_rd_addr = col0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsx_r       <= '0;
      rsy_r       <= '0;
      col_r       <= '0;
      first_r     <= 1'b1;
      s1_valid_r  <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        rsx_r   <= row_end ? '0 : rsx1;
        rsy_r   <= row_end ? '0 : rsy1;
        col_r   <= row_end ? '0 : CW'(col0 + CW'(1));
        first_r <= row_end ? 1'b0 : first0;
      end
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        total_r <= total_nxt;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_start_r <= in_data.grid_start;
      s1_first_r <= first0;
      s1_rsx_r   <= rsx1;
      s1_rsy_r   <= rsy1;
      s1_col_r   <= col0;
      // write of the item ahead lands on the same edge as this read
      fwd_r      <= s1_adv && (s1_col_r == col0);
      fwd_data_r <= {cx, cy};
    end
    if (s1_adv) begin
      out_data_r.match <= hit;
      out_data_r.total <= total_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/prefix_rectangle_balance_counter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_rectangle_balance_counter_top
// Integral image match counter over a raster stream of X/Y/empty cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one cell item per handshake (grid_start, cell_req), raster order.
//   out_* : one result item per cell (match, saturating grid total).
//   cfg_* : cfg_wr_en/cfg_wr_data set the row width; write only while idle.
//           0 acts as 1, values above MAX_COLS act as MAX_COLS.
// Throughput: one item per cycle while out_ready is high, set by the single
//   read and single write per cell of the prior-row prefix store; a
//   same-column write from the item ahead is forwarded.
// Pipeline: the accept edge loads the read-modify-write stage and issues the
//   store read; the output register and out_valid load as that stage advances.
// Reset: synchronous on rst_n low; row sums, column, total cleared, first row
//   flagged, width back to 1024. The store is not cleared; rows are written
//   before they are read. No clearing pass.
// Stall: with out_ready low the output item holds, the stage behind it holds,
//   and in_ready drops once both are full.
// ----------------------------------------------------------------------------
module prefix_rectangle_balance_counter_top #(
  parameter int MAX_COLS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  prbc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output prbc_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [prbc_pkg::CFG_W-1:0]      cfg_wr_data
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = $clog2(MAX_COLS + 1);

  logic [prbc_pkg::CFG_W-1:0]  cfg_columns_r;
  logic [RW-1:0]               cols_act;
  logic                        mem_wr_en, mem_rd_en;
  logic [CW-1:0]               mem_wr_addr, mem_rd_addr;
  logic [prbc_pkg::PAIR_W-1:0] mem_wr_data, mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_columns_r <= prbc_pkg::CFG_COLUMNS_RST;
    end else if (cfg_wr_en) begin
      cfg_columns_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (cfg_columns_r == '0) begin
      cols_act = RW'(1);
    end else if (32'(cfg_columns_r) > 32'(MAX_COLS)) begin
      cols_act = RW'(MAX_COLS);
    end else begin
      cols_act = RW'(cfg_columns_r);
    end
  end

  prbc_core #(
    .CW       (CW),
    .RW       (RW)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cols_act    (cols_act),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  prbc_row_mem #(
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for prefix_rectangle_balance_counter_top.
// Streams raster grids of X/Y/empty cells under a range of row widths and
// handshake idle patterns. A local integral-image predictor works out the
// match flag and grid total of every cell, and each result item is checked
// in order against it.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_COLS   = 1024;
  localparam int CIDX_W     = $clog2(MAX_COLS);
  localparam int WDOG_LIMIT = 20000;
  localparam int CNT_W      = prbc_pkg::CNT_W;
  localparam int PAIR_W     = prbc_pkg::PAIR_W;
  localparam int CFG_W      = prbc_pkg::CFG_W;
  localparam logic [1:0] SYM_EMPTY  = 2'd0;
  localparam logic [1:0] SYM_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  prbc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  prbc_pkg::out_item_t out_data;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;

  always #5 clk = ~clk;

  prefix_rectangle_balance_counter_top #(
    .MAX_COLS(MAX_COLS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Integral-image predictor state
  logic [PAIR_W-1:0]   col_store [MAX_COLS];
  int unsigned         written_cols;
  logic [CNT_W-1:0]    row_x;
  logic [CNT_W-1:0]    row_y;
  logic [CNT_W-1:0]    grid_total;
  int unsigned         col_pos;
  bit                  top_row;
  logic [CFG_W-1:0]    width_reg;
  prbc_pkg::out_item_t pending_results[$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned mismatches;
  int unsigned cells_sent;
  int unsigned results_seen;
  int unsigned matches_seen;
  int unsigned width_writes;
  int unsigned quiet_cycles;

  function automatic logic [CNT_W-1:0] sat_sum(logic [CNT_W-1:0] a,
                                               logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = a + b;
    return s[CNT_W] ? prbc_pkg::CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic int unsigned row_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return 32'(width_reg);
  endfunction

  task automatic integrate_cell(input prbc_pkg::in_item_t it);
    int unsigned         c;
    logic [PAIR_W-1:0]   above;
    logic [CNT_W-1:0]    cx;
    logic [CNT_W-1:0]    cy;
    prbc_pkg::out_item_t res;
    if (it.grid_start) begin
      row_x      = '0;
      row_y      = '0;
      col_pos    = 0;
      top_row    = 1'b1;
      grid_total = '0;
    end
    if (it.cell_req == prbc_pkg::SYM_X) row_x = sat_sum(row_x, CNT_W'(1));
    if (it.cell_req == prbc_pkg::SYM_Y) row_y = sat_sum(row_y, CNT_W'(1));
    c = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
    above = (top_row || c >= written_cols) ? '0 : col_store[c[CIDX_W-1:0]];
    cx = sat_sum(above[PAIR_W-1:CNT_W], row_x);
    cy = sat_sum(above[CNT_W-1:0], row_y);
    col_store[c[CIDX_W-1:0]] = {cx, cy};
    if (c + 1 > written_cols) written_cols = c + 1;
    res.match = (cx != '0) && (cx == cy);
    if (res.match) grid_total = sat_sum(grid_total, CNT_W'(1));
    res.total = grid_total;
    col_pos = c + 1;
    if (col_pos >= row_width()) begin
      col_pos = 0;
      row_x   = '0;
      row_y   = '0;
      top_row = 1'b0;
    end
    pending_results.push_back(res);
  endtask

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    prbc_pkg::out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected item: match=%0b total=%0d",
                                out_data.match, out_data.total));
      end else begin
        want = pending_results.pop_front();
        if (want.match) matches_seen++;
        if (out_data.match !== want.match)
          flag_mismatch($sformatf("match expected %0b got %0b", want.match, out_data.match));
        if (out_data.total !== want.total)
          flag_mismatch($sformatf("total expected %0d got %0d", want.total, out_data.total));
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", WDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_cell(input logic new_grid, input logic [1:0] sym);
    prbc_pkg::in_item_t it;
    it.grid_start = new_grid;
    it.cell_req   = sym;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    integrate_cell(it);
    cells_sent++;
    @(negedge clk);
  endtask

  function automatic logic [1:0] pick_symbol();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return prbc_pkg::SYM_X;
    if (r < 80) return prbc_pkg::SYM_Y;
    if (r < 95) return SYM_EMPTY;
    return SYM_UNUSED;
  endfunction

  task automatic send_run(input int unsigned n, input bit new_grid, input int unsigned noise_pct);
    for (int unsigned i = 0; i < n; i++) begin
      send_cell((new_grid && i == 0) || ($urandom_range(99) < noise_pct), pick_symbol());
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    width_reg = value;
    width_writes++;
  endtask

  task automatic set_idling(input int unsigned send_gap, input int unsigned recv_gap);
    idle_pct  = send_gap;
    stall_pct = recv_gap;
  endtask

  function automatic logic [CFG_W-1:0] random_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return 11'd1;
    if (r < 22) return 11'($urandom_range(33, 120));
    return 11'($urandom_range(2, 24));
  endfunction

  // Widening past the written columns is only safe in the top row
  function automatic logic [CFG_W-1:0] resize_target();
    int unsigned bound;
    bound = (row_width() > written_cols) ? row_width() : written_cols;
    if (top_row) bound = 64;
    if (bound > 64) bound = 64;
    return 11'($urandom_range(0, bound));
  endfunction

  task automatic test_first_cell_after_reset();
    set_idling(0, 0);
    send_cell(1'b0, prbc_pkg::SYM_X);
    send_cell(1'b0, prbc_pkg::SYM_Y);
    send_cell(1'b0, SYM_UNUSED);
    send_cell(1'b1, prbc_pkg::SYM_Y);
    send_cell(1'b0, prbc_pkg::SYM_X);
    drain_results();
  endtask

  task automatic test_width_extremes();
    write_width('0);
    send_cell(1'b1, prbc_pkg::SYM_X);
    send_cell(1'b0, prbc_pkg::SYM_Y);
    send_cell(1'b0, SYM_EMPTY);
    send_cell(1'b0, SYM_UNUSED);
    send_cell(1'b0, prbc_pkg::SYM_Y);
    send_cell(1'b0, prbc_pkg::SYM_X);
    drain_results();
    write_width('1);
    send_cell(1'b1, prbc_pkg::SYM_Y);
    send_cell(1'b0, prbc_pkg::SYM_X);
    drain_results();
  endtask

  task automatic test_mid_grid_resize();
    write_width(11'd3);
    send_cell(1'b1, prbc_pkg::SYM_X);
    send_cell(1'b0, prbc_pkg::SYM_Y);
    send_cell(1'b0, prbc_pkg::SYM_Y);
    send_cell(1'b0, prbc_pkg::SYM_X);
    send_cell(1'b0, prbc_pkg::SYM_X);
    drain_results();
    // column already at the new width: row ends after the next cell
    write_width(11'd2);
    send_cell(1'b0, prbc_pkg::SYM_Y);
    send_cell(1'b0, prbc_pkg::SYM_Y);
    send_cell(1'b0, prbc_pkg::SYM_X);
    drain_results();
    write_width(11'd3);
    send_cell(1'b0, prbc_pkg::SYM_Y);
    send_cell(1'b0, prbc_pkg::SYM_X);
    send_cell(1'b0, prbc_pkg::SYM_Y);
    drain_results();
  endtask

  task automatic test_full_width_rows();
    set_idling(9, 9);
    write_width(11'd1024);
    send_run(MAX_COLS + 40, 1'b1, 0);
    drain_results();
  endtask

  task automatic test_output_hold_off();
    set_idling(0, 0);
    write_width(11'd5);
    hold_req = 200;
    send_run(60, 1'b1, 0);
    drain_results();
  endtask

  task automatic test_random_grids();
    int unsigned send_gap [4] = '{0, 73, 0, 9};
    int unsigned recv_gap [4] = '{0, 0, 73, 9};
    int unsigned budget;
    int unsigned eff;
    int unsigned rows;
    int unsigned n;
    for (int m = 0; m < 4; m++) begin
      set_idling(send_gap[m], recv_gap[m]);
      budget = cells_sent + 150;
      while (cells_sent < budget) begin
        drain_results();
        write_width(random_width());
        eff  = row_width();
        rows = (eff > 24) ? 1 : $urandom_range(1, 6);
        n    = rows * eff + $urandom_range(0, eff - 1);
        if ($urandom_range(3) == 0) begin
          send_run(n / 2 + 1, 1'b1, 3);
          drain_results();
          write_width(resize_target());
          send_run(n - n / 2, 1'b0, 3);
        end else begin
          send_run(n, 1'b1, 3);
        end
      end
    end
    drain_results();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_req     = 0;
    hold_left    = 0;
    mismatches   = 0;
    cells_sent   = 0;
    results_seen = 0;
    matches_seen = 0;
    width_writes = 0;
    quiet_cycles = 0;
    written_cols = 0;
    row_x        = '0;
    row_y        = '0;
    grid_total   = '0;
    col_pos      = 0;
    top_row      = 1'b1;
    width_reg    = prbc_pkg::CFG_COLUMNS_RST;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_first_cell_after_reset();
    test_width_extremes();
    test_mid_grid_resize();
    test_full_width_rows();
    test_output_hold_off();
    test_random_grids();

    drain_results();
    repeat (8) @(negedge clk);
    $display("Sent %0d cells across %0d row-width writes; %0d results checked, %0d matches.",
             cells_sent, width_writes, results_seen, matches_seen);
    $display("Covered widths 0/1/1024/2047, mid-grid resizes, output hold-off, idle mixes.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
